FILE: sv/msf1_pkg.sv
// Shared types and constants for the masked segmentation F1 score block.
// No dependencies; used by msf1_ctrl, msf1_datapath and the top level.
package msf1_pkg;

  localparam logic [7:0] FG_VALUE = 8'h00;
  localparam logic [7:0] BG_VALUE = 8'hFF;

  // Which ratio the shared divider is working on
  typedef enum logic [1:0] {
    SEL_PREC = 2'd0,
    SEL_REC  = 2'd1,
    SEL_F1   = 2'd2
  } div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_DIV   = 5'b00100,
    S_STORE = 5'b01000,
    S_OUT   = 5'b10000
  } msf1_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     count;  // pixel word accepted
    logic     snap;   // frame end: latch floored counts, clear counters
    logic     load;   // load divider operands for sel
    logic     step;   // one restoring-division step
    logic     store;  // write quotient to the result slot for sel
    div_sel_t sel;
  } msf1_cmd_t;

endpackage

FILE: sv/msf1_ctrl.sv
// Sequencer for the F1 score block: handshakes and the three-pass divider schedule.
// Depends on msf1_pkg.
module msf1_ctrl import msf1_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_pixel,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output msf1_cmd_t cmd
);

  localparam int SW = $clog2(FRACTION_BITS + 1);

  msf1_state_t    state_r, state_nxt;
  div_sel_t       sel_r, sel_nxt;
  logic [SW-1:0]  step_r, step_nxt;
  logic           in_acc;
  logic           last_step;

  // Pixels keep flowing during division; only a frame end has to wait.
  assign in_stall  = in_last_pixel && (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign last_step = (step_r == SW'(FRACTION_BITS));

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    step_nxt  = step_r;
    cmd.count = in_acc;
    cmd.snap  = in_acc && in_last_pixel;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    cmd.store = 1'b0;
    cmd.sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.snap) begin
          state_nxt = S_LOAD;
          sel_nxt   = SEL_PREC;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        case (sel_r)
          SEL_PREC: begin
            sel_nxt   = SEL_REC;
            state_nxt = S_LOAD;
          end
          SEL_REC: begin
            sel_nxt   = SEL_F1;
            state_nxt = S_LOAD;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_PREC;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

FILE: sv/msf1_datapath.sv
// Datapath: saturating tp/fp/fn counters, frame snapshot, shared bit-serial
// divider and result registers. Depends on msf1_pkg.
module msf1_datapath import msf1_pkg::*; #(
  parameter int PIXEL_COUNT_LOG2 = 22,
  parameter int FRACTION_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  msf1_cmd_t                   cmd,
  input  logic [7:0]                  mask_pixel,
  input  logic [7:0]                  predicted_pixel,
  input  logic [7:0]                  target_pixel,
  output logic [PIXEL_COUNT_LOG2:0]   true_pos,
  output logic [PIXEL_COUNT_LOG2:0]   false_pos,
  output logic [PIXEL_COUNT_LOG2:0]   false_neg,
  output logic [FRACTION_BITS:0]      precision_q16,
  output logic [FRACTION_BITS:0]      recall_q16,
  output logic [FRACTION_BITS:0]      f1_q16
);

  localparam int CW = PIXEL_COUNT_LOG2 + 1;  // count width
  localparam int DW = PIXEL_COUNT_LOG2 + 3;  // divider operand width
  localparam int QW = FRACTION_BITS + 1;     // quotient width

  logic [CW-1:0] tp_cnt_r, fp_cnt_r, fn_cnt_r;
  logic [CW-1:0] tp_inc, fp_inc, fn_inc;
  logic [CW-1:0] tp_r, fp_r, fn_r;
  logic          hit_tp, hit_fp, hit_fn;
  logic          p_fg, p_bg, t_fg, t_bg, in_mask;

  logic [DW-1:0] rem_r, den_r;
  logic [DW-1:0] num_ld, den_ld, rem_sub;
  logic          q_bit;
  logic [QW-1:0] quo_r;
  logic [QW-1:0] prec_r, rec_r, f1_r;

  assign p_fg    = (predicted_pixel == FG_VALUE);
  assign p_bg    = (predicted_pixel == BG_VALUE);
  assign t_fg    = (target_pixel == FG_VALUE);
  assign t_bg    = (target_pixel == BG_VALUE);
  assign in_mask = (mask_pixel != 8'd0);
  assign hit_tp  = cmd.count && in_mask && p_fg && t_fg;
  assign hit_fp  = cmd.count && in_mask && p_fg && t_bg;
  assign hit_fn  = cmd.count && in_mask && p_bg && t_fg;

  // Counts never exceed 2^P, so the top bit alone marks saturation.
  assign tp_inc = (hit_tp && !tp_cnt_r[CW-1]) ? tp_cnt_r + 1'b1 : tp_cnt_r;
  assign fp_inc = (hit_fp && !fp_cnt_r[CW-1]) ? fp_cnt_r + 1'b1 : fp_cnt_r;
  assign fn_inc = (hit_fn && !fn_cnt_r[CW-1]) ? fn_cnt_r + 1'b1 : fn_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_cnt_r <= '0;
      fp_cnt_r <= '0;
      fn_cnt_r <= '0;
    end else if (cmd.snap) begin
      tp_cnt_r <= '0;
      fp_cnt_r <= '0;
      fn_cnt_r <= '0;
    end else begin
      tp_cnt_r <= tp_inc;
      fp_cnt_r <= fp_inc;
      fn_cnt_r <= fn_inc;
    end
  end

  // Frame snapshot, zero counts floored at one
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      tp_r <= (tp_inc == '0) ? CW'(1) : tp_inc;
      fp_r <= (fp_inc == '0) ? CW'(1) : fp_inc;
      fn_r <= (fn_inc == '0) ? CW'(1) : fn_inc;
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_PREC: begin
        num_ld = DW'(tp_r);
        den_ld = DW'(tp_r) + DW'(fp_r);
      end
      SEL_REC: begin
        num_ld = DW'(tp_r);
        den_ld = DW'(tp_r) + DW'(fn_r);
      end
      default: begin
        num_ld = DW'(tp_r) << 1;
        den_ld = (DW'(tp_r) << 1) + DW'(fp_r) + DW'(fn_r);
      end
    endcase
  end

  // Restoring division, one quotient bit per step, MSB (weight 2^F) first.
  // num <= den keeps the remainder below den, so the shifted value fits DW.
  assign q_bit   = (rem_r >= den_r);
  assign rem_sub = q_bit ? rem_r - den_r : rem_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= num_ld;
      den_r <= den_ld;
      quo_r <= '0;
    end else if (cmd.step) begin
      rem_r <= rem_sub << 1;
      quo_r <= {quo_r[QW-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.sel)
        SEL_PREC: prec_r <= quo_r;
        SEL_REC:  rec_r  <= quo_r;
        default:  f1_r   <= quo_r;
      endcase
    end
  end

  assign true_pos      = tp_r;
  assign false_pos     = fp_r;
  assign false_neg     = fn_r;
  assign precision_q16 = prec_r;
  assign recall_q16    = rec_r;
  assign f1_q16        = f1_r;

endmodule

FILE: sv/masked_segmentation_f1_score_top.sv
// Masked binary segmentation F1 score: pixel word in, one score word per image.
// Pixel words are taken one per clock, including while the previous image's
// scores are being computed. A word flagged last_pixel closes the image:
// precision, recall and F1 come from one shared restoring divider producing a
// quotient bit per cycle, after which the score word is offered on out_*. A
// last pixel is held off (in_stall) until that score word has been taken; all
// other pixels are never stalled. Depends on msf1_pkg, msf1_ctrl and
// msf1_datapath.
module masked_segmentation_f1_score_top import msf1_pkg::*; #(
  parameter int PIXEL_COUNT_LOG2 = 22,
  parameter int FRACTION_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_mask_pixel,
  input  logic [7:0]                in_predicted_pixel,
  input  logic [7:0]                in_target_pixel,
  input  logic                      in_last_pixel,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PIXEL_COUNT_LOG2:0] out_true_pos,
  output logic [PIXEL_COUNT_LOG2:0] out_false_pos,
  output logic [PIXEL_COUNT_LOG2:0] out_false_neg,
  output logic [FRACTION_BITS:0]    out_precision_q16,
  output logic [FRACTION_BITS:0]    out_recall_q16,
  output logic [FRACTION_BITS:0]    out_f1_q16
);

  msf1_cmd_t cmd;

  msf1_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_pixel(in_last_pixel),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  msf1_datapath #(
    .PIXEL_COUNT_LOG2(PIXEL_COUNT_LOG2),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .mask_pixel     (in_mask_pixel),
    .predicted_pixel(in_predicted_pixel),
    .target_pixel   (in_target_pixel),
    .true_pos       (out_true_pos),
    .false_pos      (out_false_pos),
    .false_neg      (out_false_neg),
    .precision_q16  (out_precision_q16),
    .recall_q16     (out_recall_q16),
    .f1_q16         (out_f1_q16)
  );

endmodule

FILE: bench/msf1_score_checker.sv
`timescale 1ns / 100ps
// Score checker for masked_segmentation_f1_score_top: watches the pixel and score
// channels, predicts each score word and compares it field by field.
// Depends on msf1_pkg for the foreground and background grey values.
module msf1_score_checker import msf1_pkg::*; #(
  parameter int PIXEL_COUNT_LOG2 = 22,
  parameter int FRACTION_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [7:0]                in_mask_pixel,
  input  logic [7:0]                in_predicted_pixel,
  input  logic [7:0]                in_target_pixel,
  input  logic                      in_last_pixel,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [PIXEL_COUNT_LOG2:0] out_true_pos,
  input  logic [PIXEL_COUNT_LOG2:0] out_false_pos,
  input  logic [PIXEL_COUNT_LOG2:0] out_false_neg,
  input  logic [FRACTION_BITS:0]    out_precision_q16,
  input  logic [FRACTION_BITS:0]    out_recall_q16,
  input  logic [FRACTION_BITS:0]    out_f1_q16,
  output int                        mismatches,
  output int                        scores_pending,
  output int                        scores_checked
);

  localparam longint unsigned COUNT_CEIL = 64'd1 << PIXEL_COUNT_LOG2;

  typedef struct {
    longint unsigned true_pos;
    longint unsigned false_pos;
    longint unsigned false_neg;
    longint unsigned precision;
    longint unsigned recall;
    longint unsigned f1;
  } score_word_t;

  score_word_t     expected_scores[$];
  longint unsigned tp_count;
  longint unsigned fp_count;
  longint unsigned fn_count;

  function automatic longint unsigned bump(input longint unsigned n);
    return (n >= COUNT_CEIL) ? COUNT_CEIL : n + 1;
  endfunction

  function automatic longint unsigned at_least_one(input longint unsigned n);
    return (n == 0) ? 1 : n;
  endfunction

  task automatic report(input string what);
    if (mismatches < 10) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input logic [63:0] got);
    if (got !== want) report($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  task automatic tally_pixel();
    score_word_t     s;
    longint unsigned tp;
    longint unsigned fp;
    longint unsigned fn;
    if (in_mask_pixel != 8'd0) begin
      if (in_predicted_pixel == FG_VALUE && in_target_pixel == FG_VALUE)
        tp_count = bump(tp_count);
      if (in_predicted_pixel == FG_VALUE && in_target_pixel == BG_VALUE)
        fp_count = bump(fp_count);
      if (in_predicted_pixel == BG_VALUE && in_target_pixel == FG_VALUE)
        fn_count = bump(fn_count);
    end
    if (in_last_pixel) begin
      // empty counts are taken as one, so no ratio divides by zero
      tp = at_least_one(tp_count);
      fp = at_least_one(fp_count);
      fn = at_least_one(fn_count);
      s.true_pos  = tp;
      s.false_pos = fp;
      s.false_neg = fn;
      s.precision = (tp << FRACTION_BITS) / (tp + fp);
      s.recall    = (tp << FRACTION_BITS) / (tp + fn);
      s.f1        = ((2 * tp) << FRACTION_BITS) / (2 * tp + fp + fn);
      expected_scores.push_back(s);
      tp_count = 0;
      fp_count = 0;
      fn_count = 0;
    end
  endtask

  task automatic check_score_word();
    score_word_t s;
    if (expected_scores.size() == 0) begin
      report("score word with no image closed");
      return;
    end
    s = expected_scores.pop_front();
    scores_checked++;
    check_field("true_pos", s.true_pos, out_true_pos);
    check_field("false_pos", s.false_pos, out_false_pos);
    check_field("false_neg", s.false_neg, out_false_neg);
    check_field("precision_q16", s.precision, out_precision_q16);
    check_field("recall_q16", s.recall, out_recall_q16);
    check_field("f1_q16", s.f1, out_f1_q16);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tp_count = 0;
      fp_count = 0;
      fn_count = 0;
      expected_scores.delete();
      mismatches = 0;
      scores_checked = 0;
    end else begin
      // score word out first: a word closing an image this edge is never the one leaving
      if (out_valid && !out_stall) check_score_word();
      if (in_valid && !in_stall) tally_pixel();
    end
    scores_pending = expected_scores.size();
  end

endmodule

FILE: bench/masked_segmentation_f1_score_top_test.sv
`timescale 1ns / 100ps
// Testbench top for masked_segmentation_f1_score_top: drives pixel words and
// score-channel stalls, gives the verdict. Depends on msf1_pkg and msf1_score_checker.
module masked_segmentation_f1_score_top_test import msf1_pkg::*;;

  localparam int PIXEL_COUNT_LOG2 = 22;
  localparam int FRACTION_BITS    = 16;
  localparam int SCORE_LATENCY    = 3 * (FRACTION_BITS + 3);
  localparam int QUIET_LIMIT      = 2000;
  localparam int WORDS_PER_PHASE  = 310;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_mask_pixel = 8'd0;
  logic [7:0] in_predicted_pixel = 8'd0;
  logic [7:0] in_target_pixel = 8'd0;
  logic       in_last_pixel = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;

  logic [PIXEL_COUNT_LOG2:0] out_true_pos;
  logic [PIXEL_COUNT_LOG2:0] out_false_pos;
  logic [PIXEL_COUNT_LOG2:0] out_false_neg;
  logic [FRACTION_BITS:0]    out_precision_q16;
  logic [FRACTION_BITS:0]    out_recall_q16;
  logic [FRACTION_BITS:0]    out_f1_q16;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int counted_words = 0;
  int pixel_words = 0;
  int quiet_cycles = 0;
  int mismatches;
  int scores_pending;
  int scores_checked;

  masked_segmentation_f1_score_top #(
    .PIXEL_COUNT_LOG2(PIXEL_COUNT_LOG2),
    .FRACTION_BITS   (FRACTION_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mask_pixel     (in_mask_pixel),
    .in_predicted_pixel(in_predicted_pixel),
    .in_target_pixel   (in_target_pixel),
    .in_last_pixel     (in_last_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_true_pos      (out_true_pos),
    .out_false_pos     (out_false_pos),
    .out_false_neg     (out_false_neg),
    .out_precision_q16 (out_precision_q16),
    .out_recall_q16    (out_recall_q16),
    .out_f1_q16        (out_f1_q16)
  );

  msf1_score_checker #(
    .PIXEL_COUNT_LOG2(PIXEL_COUNT_LOG2),
    .FRACTION_BITS   (FRACTION_BITS)
  ) score_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mask_pixel     (in_mask_pixel),
    .in_predicted_pixel(in_predicted_pixel),
    .in_target_pixel   (in_target_pixel),
    .in_last_pixel     (in_last_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_true_pos      (out_true_pos),
    .out_false_pos     (out_false_pos),
    .out_false_neg     (out_false_neg),
    .out_precision_q16 (out_precision_q16),
    .out_recall_q16    (out_recall_q16),
    .out_f1_q16        (out_f1_q16),
    .mismatches        (mismatches),
    .scores_pending    (scores_pending),
    .scores_checked    (scores_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // any handshake on either channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // called and returns at a falling edge; word held until accepted
  task automatic push_pixel(input logic [7:0] mask, input logic [7:0] pred,
                            input logic [7:0] targ, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_mask_pixel      = mask;
    in_predicted_pixel = pred;
    in_target_pixel    = targ;
    in_last_pixel      = last;
    do @(posedge clk); while (in_stall !== 1'b0);
    pixel_words++;
    if (mask != 8'd0 || last) counted_words++;
    @(negedge clk);
  endtask

  // mostly clean foreground/background, some odd greys
  function automatic logic [7:0] pick_grey(input int fg_pct);
    if ($urandom_range(99) < 8) return 8'($urandom_range(255));
    return ($urandom_range(99) < fg_pct) ? FG_VALUE : BG_VALUE;
  endfunction

  task automatic random_images(input int quota);
    int         stop_at;
    int         len;
    int         pred_fg;
    int         targ_fg;
    int         skip_pct;
    int         k;
    logic [7:0] m;
    stop_at = pixel_words + quota;
    while (pixel_words < stop_at) begin
      len      = ($urandom_range(19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      pred_fg  = $urandom_range(100);
      targ_fg  = $urandom_range(100);
      skip_pct = ($urandom_range(7) == 0) ? 100 : $urandom_range(30);
      for (k = 0; k < len; k++) begin
        m = ($urandom_range(99) < skip_pct) ? 8'd0 : 8'($urandom_range(1, 255));
        push_pixel(m, pick_grey(pred_fg), pick_grey(targ_fg), k == len - 1);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct  = 36;
    recv_stall_pct = 77;
    // image with nothing counted: every count floors to one
    push_pixel(8'h00, FG_VALUE, FG_VALUE, 1'b1);
    // lone true positive at full mask
    push_pixel(8'hFF, FG_VALUE, FG_VALUE, 1'b1);
    // mixed image: each class, true negative, odd greys, skipped pixels
    push_pixel(8'h01, FG_VALUE, FG_VALUE, 1'b0);
    push_pixel(8'h80, FG_VALUE, BG_VALUE, 1'b0);
    push_pixel(8'hFF, BG_VALUE, FG_VALUE, 1'b0);
    push_pixel(8'h7F, BG_VALUE, BG_VALUE, 1'b0);
    push_pixel(8'h01, 8'h80, FG_VALUE, 1'b0);
    push_pixel(8'h01, FG_VALUE, 8'h01, 1'b0);
    push_pixel(8'h01, 8'hFE, FG_VALUE, 1'b0);
    push_pixel(8'h01, BG_VALUE, 8'h7F, 1'b0);
    push_pixel(8'h00, FG_VALUE, BG_VALUE, 1'b0);
    push_pixel(8'h00, BG_VALUE, FG_VALUE, 1'b0);
    push_pixel(8'h55, FG_VALUE, FG_VALUE, 1'b1);
    // false positives only
    push_pixel(8'hAA, FG_VALUE, BG_VALUE, 1'b0);
    push_pixel(8'hAA, FG_VALUE, BG_VALUE, 1'b0);
    push_pixel(8'h01, FG_VALUE, BG_VALUE, 1'b1);
    // false negatives only
    push_pixel(8'h01, BG_VALUE, FG_VALUE, 1'b0);
    push_pixel(8'h01, BG_VALUE, FG_VALUE, 1'b1);
    // last pixel with odd greys counts nowhere
    push_pixel(8'hFF, 8'h80, 8'h80, 1'b1);
    random_images(WORDS_PER_PHASE);

    send_idle_pct  = 77;
    recv_stall_pct = 36;
    random_images(WORDS_PER_PHASE);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_images(WORDS_PER_PHASE);

    in_valid = 1'b0;
    wait (scores_pending == 0);
    repeat (SCORE_LATENCY + 20) @(posedge clk);

    $display("Sent %0d pixel words (%0d masked or closing) under three pacing phases;",
             pixel_words, counted_words);
    $display("checked %0d score words, %0d field mismatches.", scores_checked, mismatches);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
sv/msf1_pkg.sv
sv/msf1_ctrl.sv
sv/msf1_datapath.sv
sv/masked_segmentation_f1_score_top.sv
bench/msf1_score_checker.sv
bench/masked_segmentation_f1_score_top_test.sv
